[hw/rtl/qadd_pkg.sv]
// Shared types and constants for the quantized u8 add / requantize block.
// Depends on nothing; used by the channel interfaces, the pipeline and the top level.
package qadd_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PROD_W     = 31;  // 8 x 23 unsigned product
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned WIDE_W     = 34;  // shifted value + round + zero point, no wrap

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIAS_PRODUCT    = 4'd0,
    REG_A_GAIN          = 4'd1,
    REG_B_GAIN          = 4'd2,
    REG_SHIFT_AMOUNT    = 4'd3,
    REG_ROUND_THRESHOLD = 4'd4,
    REG_OUT_ZERO_POINT  = 4'd5,
    REG_OUT_MIN         = 4'd6,
    REG_OUT_MAX         = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] bias_product;
    logic [22:0] a_gain;
    logic [22:0] b_gain;
    logic [4:0]  shift_amount;
    logic [30:0] round_threshold;
    logic [7:0]  out_zero_point;
    logic [7:0]  out_min;
    logic [7:0]  out_max;
  } cfg_t;

endpackage

[hw/rtl/qadd_if.sv]
// Channel interfaces: operand request, result request and register write.
// Depends on qadd_pkg for the register port widths.
interface qadd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] a_value;
  logic [7:0] b_value;
  logic       is_last;

  modport source (output valid, a_value, b_value, is_last, input ready);
  modport sink   (input valid, a_value, b_value, is_last, output ready);
endinterface

interface qadd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sum_value;
  logic       last_out;

  modport source (output valid, sum_value, last_out, input ready);
  modport sink   (input valid, sum_value, last_out, output ready);
endinterface

interface qadd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [qadd_pkg::CFG_IDX_W-1:0]     index;
  logic [qadd_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/qadd_pipe.sv]
// Five-stage requantizing add datapath: multiply, accumulate, shift/round,
// zero point, clamp. Depends on qadd_pkg and the channel interfaces in qadd_if.sv.
module qadd_pipe (
  input  logic           clk,
  input  logic           rst_n,
  input  qadd_pkg::cfg_t cfg,
  qadd_in_if.sink        in_ch,
  qadd_out_if.source     out_ch
);
  import qadd_pkg::*;

  // per-stage valid bits and ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // stage payloads
  logic [PROD_W-1:0]        pa_r, pb_r;
  logic                     l1_r, l2_r, l3_r, l4_r, l5_r;
  logic [ACC_W-1:0]         acc_r;
  logic signed [ACC_W-1:0]  sh_r;
  logic                     rnd_r;
  logic signed [WIDE_W-1:0] y_r;
  logic [7:0]               sum_r;

  // next values
  logic [PROD_W-1:0]        pa_nxt, pb_nxt;
  logic [ACC_W-1:0]         acc_nxt;
  logic [ACC_W-1:0]         mask;
  logic [PROD_W-1:0]        rem_bits;
  logic [ACC_W-1:0]         thr_adj;
  logic signed [ACC_W-1:0]  sh_nxt;
  logic                     rnd_nxt;
  logic signed [WIDE_W-1:0] y_nxt;
  logic signed [WIDE_W-1:0] lo_w, hi_w, y_lo;
  logic [7:0]               sum_nxt;

  assign rdy5 = !v5_r || out_ch.ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  always_comb begin
    pa_nxt = PROD_W'({23'd0, in_ch.a_value} * {8'd0, cfg.a_gain});
    pb_nxt = PROD_W'({23'd0, in_ch.b_value} * {8'd0, cfg.b_gain});
  end

  // accumulator wraps modulo 2^32
  assign acc_nxt = cfg.bias_product + {1'b0, pa_r} + {1'b0, pb_r};

  // negative accumulators take one off the remainder: round when rem > thr + neg
  always_comb begin
    mask     = (ACC_W'(1) << cfg.shift_amount) - ACC_W'(1);
    rem_bits = acc_r[PROD_W-1:0] & mask[PROD_W-1:0];
    thr_adj  = {1'b0, cfg.round_threshold} + ACC_W'(acc_r[ACC_W-1]);
    rnd_nxt  = {1'b0, rem_bits} > thr_adj;
    sh_nxt   = $signed(acc_r) >>> cfg.shift_amount;
  end

  assign y_nxt = $signed({{(WIDE_W-ACC_W){sh_r[ACC_W-1]}}, sh_r})
               + $signed({{(WIDE_W-1){1'b0}}, rnd_r})
               + $signed({{(WIDE_W-8){1'b0}}, cfg.out_zero_point});

  // lower bound first, upper bound last
  always_comb begin
    lo_w    = $signed({{(WIDE_W-8){1'b0}}, cfg.out_min});
    hi_w    = $signed({{(WIDE_W-8){1'b0}}, cfg.out_max});
    y_lo    = (y_r < lo_w) ? lo_w : y_r;
    sum_nxt = (y_lo > hi_w) ? cfg.out_max : y_lo[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
      l1_r <= in_ch.is_last;
    end
    if (rdy2 && v1_r) begin
      acc_r <= acc_nxt;
      l2_r  <= l1_r;
    end
    if (rdy3 && v2_r) begin
      sh_r  <= sh_nxt;
      rnd_r <= rnd_nxt;
      l3_r  <= l2_r;
    end
    if (rdy4 && v3_r) begin
      y_r  <= y_nxt;
      l4_r <= l3_r;
    end
    if (rdy5 && v4_r) begin
      sum_r <= sum_nxt;
      l5_r  <= l4_r;
    end
  end

  assign out_ch.valid     = v5_r;
  assign out_ch.sum_value = sum_r;
  assign out_ch.last_out  = l5_r;

  // a request in stage one with room downstream must show up in stage two
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && rdy2) |=> v2_r)
    else $error("stage one request lost on advance");

  // a stalled result must not be overwritten by the stage behind it
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && !out_ch.ready) |=> (v5_r && $stable(sum_r) && $stable(l5_r)))
    else $error("stalled result changed");

  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && cfg.out_min <= cfg.out_max)
      |-> (sum_r >= cfg.out_min && sum_r <= cfg.out_max))
    else $error("result outside clamp bounds");

  a_inverted: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && cfg.out_min > cfg.out_max) |-> (sum_r == cfg.out_max))
    else $error("inverted bounds must give the upper bound");

endmodule

[hw/rtl/quantized_u8_add_requantize.sv]
// Top level of the quantized u8 elementwise add with requantization.
// Holds the register file and the datapath; depends on qadd_pkg, qadd_if.sv, qadd_pipe.
//
//   channel  | dir | payload                          | handshake
//   in_ch    | in  | a_value[8] b_value[8] is_last[1] | valid/ready
//   out_ch   | out | sum_value[8] last_out[1]         | valid/ready
//   cfg_ch   | in  | index[4] data[32]                | valid/ready, ready always high
//
// One request per cycle sustained while out_ch does not stall; each result passes
// through five registered stages: multiply, accumulate, shift/round, zero point, clamp.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
// A stall on out_ch backs up stage by stage; empty stages keep filling meanwhile.
// Register writes take effect at once; write them only while the pipeline is empty.
module quantized_u8_add_requantize (
  input  logic       clk,
  input  logic       rst_n,
  qadd_in_if.sink    in_ch,
  qadd_out_if.source out_ch,
  qadd_cfg_if.sink   cfg_ch
);
  import qadd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_BIAS_PRODUCT:    cfg_nxt.bias_product    = cfg_ch.data;
        REG_A_GAIN:          cfg_nxt.a_gain          = cfg_ch.data[22:0];
        REG_B_GAIN:          cfg_nxt.b_gain          = cfg_ch.data[22:0];
        REG_SHIFT_AMOUNT:    cfg_nxt.shift_amount    = cfg_ch.data[4:0];
        REG_ROUND_THRESHOLD: cfg_nxt.round_threshold = cfg_ch.data[30:0];
        REG_OUT_ZERO_POINT:  cfg_nxt.out_zero_point  = cfg_ch.data[7:0];
        REG_OUT_MIN:         cfg_nxt.out_min         = cfg_ch.data[7:0];
        REG_OUT_MAX:         cfg_nxt.out_max         = cfg_ch.data[7:0];
        default:             cfg_nxt = cfg_r;  // drop writes past the last register
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bias_product    <= '0;
      cfg_r.a_gain          <= '0;
      cfg_r.b_gain          <= '0;
      cfg_r.shift_amount    <= '0;
      cfg_r.round_threshold <= '0;
      cfg_r.out_zero_point  <= '0;
      cfg_r.out_min         <= '0;
      cfg_r.out_max         <= 8'hFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  qadd_pipe u_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
